// ===== rtl/m4cm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package m4cm_pkg;

    localparam int NUM_ROWS = 4;
    localparam int ROW_W    = 2;
    localparam int COL_W    = 2;
    localparam int STORE_W  = COL_W + ROW_W;

    typedef enum logic
    {
        OP_LOAD     = 1'b0,
        OP_MULTIPLY = 1'b1
    } m4cm_op_t;

    // per-stage advance enables shared by the lanes
    typedef struct packed
    {
        logic s1;
        logic s2;
        logic s3;
    } m4cm_adv_t;

endpackage

`default_nettype wire

// ===== rtl/m4cm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface m4cm_in_if #(
    parameter int DATA_WIDTH = 32
);
    import m4cm_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [0:0]                   operation;
    logic [COL_W-1:0]             column;
    logic signed [DATA_WIDTH-1:0] elem_row0;
    logic signed [DATA_WIDTH-1:0] elem_row1;
    logic signed [DATA_WIDTH-1:0] elem_row2;
    logic signed [DATA_WIDTH-1:0] elem_row3;

    modport source
    (
        output valid, operation, column, elem_row0, elem_row1, elem_row2, elem_row3,
        input  ready
    );

    modport sink
    (
        input  valid, operation, column, elem_row0, elem_row1, elem_row2, elem_row3,
        output ready
    );

endinterface

interface m4cm_out_if #(
    parameter int DATA_WIDTH = 32
);
    import m4cm_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [COL_W-1:0]             result_column;
    logic signed [DATA_WIDTH-1:0] prod_row0;
    logic signed [DATA_WIDTH-1:0] prod_row1;
    logic signed [DATA_WIDTH-1:0] prod_row2;
    logic signed [DATA_WIDTH-1:0] prod_row3;
    logic                         saturated;

    modport source
    (
        output valid, result_column, prod_row0, prod_row1, prod_row2, prod_row3, saturated,
        input  ready
    );

    modport sink
    (
        input  valid, result_column, prod_row0, prod_row1, prod_row2, prod_row3, saturated,
        output ready
    );

endinterface

`default_nettype wire

// ===== rtl/m4cm_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module m4cm_lane #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  wire logic                         clk,
    input  wire m4cm_pkg::m4cm_adv_t          adv,
    input  wire logic signed [DATA_WIDTH-1:0] left_row [m4cm_pkg::NUM_ROWS],
    input  wire logic signed [DATA_WIDTH-1:0] right_col [m4cm_pkg::NUM_ROWS],
    output logic signed [DATA_WIDTH-1:0]      value,
    output logic                              clipped
);
    import m4cm_pkg::*;

    localparam int LO_W = DATA_WIDTH / 2;
    localparam int HI_W = DATA_WIDTH - LO_W;
    localparam int PW   = 2 * DATA_WIDTH;
    localparam int SW   = PW + 2;

    localparam logic signed [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // right element split in a signed upper half and an unsigned lower half
    logic signed [DATA_WIDTH+HI_W-1:0] pp_hi_reg  [NUM_ROWS];
    logic signed [DATA_WIDTH+HI_W-1:0] pp_hi_next [NUM_ROWS];
    logic signed [DATA_WIDTH+LO_W:0]   pp_lo_reg  [NUM_ROWS];
    logic signed [DATA_WIDTH+LO_W:0]   pp_lo_next [NUM_ROWS];
    logic signed [PW-1:0]              prod_reg   [NUM_ROWS];
    logic signed [PW-1:0]              prod_next  [NUM_ROWS];
    logic signed [SW-1:0]              sum_reg;
    logic signed [SW-1:0]              sum_next;
    logic signed [SW-1:0]              shifted;
    logic        [SW-DATA_WIDTH:0]     upper;

    always_comb
    begin
        for (int k = 0; k < NUM_ROWS; k++)
        begin
            pp_hi_next[k] = (DATA_WIDTH+HI_W)'(left_row[k])
                          * (DATA_WIDTH+HI_W)'($signed(right_col[k][DATA_WIDTH-1:LO_W]));
            pp_lo_next[k] = (DATA_WIDTH+LO_W+1)'(left_row[k])
                          * (DATA_WIDTH+LO_W+1)'($signed({1'b0, right_col[k][LO_W-1:0]}));
            prod_next[k]  = (PW'(pp_hi_reg[k]) <<< LO_W) + PW'(pp_lo_reg[k]);
        end
        sum_next = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2]) + SW'(prod_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            pp_hi_reg <= pp_hi_next;
            pp_lo_reg <= pp_lo_next;
        end
        if (adv.s2)
        begin
            prod_reg <= prod_next;
        end
        if (adv.s3)
        begin
            sum_reg <= sum_next;
        end
    end

    // floor shift, then clamp to the signed data range
    always_comb
    begin
        shifted = sum_reg >>> FRAC_BITS;
        upper   = shifted[SW-1:DATA_WIDTH-1];
        clipped = !((&upper) || !(|upper));
        if (!clipped)
        begin
            value = shifted[DATA_WIDTH-1:0];
        end
        else if (shifted[SW-1])
        begin
            value = MIN_VAL;
        end
        else
        begin
            value = MAX_VAL;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/m4cm_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module m4cm_merge #(
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic [m4cm_pkg::COL_W-1:0]   in_column,
    input  wire logic signed [DATA_WIDTH-1:0] lane_value [m4cm_pkg::NUM_ROWS],
    input  wire logic [m4cm_pkg::NUM_ROWS-1:0] lane_clip,
    output logic                              out_free,
    m4cm_out_if.source                        results
);
    import m4cm_pkg::*;

    logic                         valid_reg;
    logic                         valid_next;
    logic                         load;
    logic [COL_W-1:0]             column_reg;
    logic signed [DATA_WIDTH-1:0] prod_reg [NUM_ROWS];
    logic                         sat_reg;

    always_comb
    begin
        out_free   = !valid_reg || results.ready;
        load       = in_valid && out_free;
        valid_next = load || (valid_reg && !results.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            column_reg <= in_column;
            prod_reg   <= lane_value;
            sat_reg    <= |lane_clip;
        end
    end

    assign results.valid         = valid_reg;
    assign results.result_column = column_reg;
    assign results.prod_row0     = prod_reg[0];
    assign results.prod_row1     = prod_reg[1];
    assign results.prod_row2     = prod_reg[2];
    assign results.prod_row3     = prod_reg[3];
    assign results.saturated     = sat_reg;

endmodule

`default_nettype wire

// ===== rtl/matrix4_column_multiply.sv =====
`timescale 1ns / 1ps
`default_nettype none

// 4x4 column-major matrix product, signed fixed point (Q16.16 by default).
// requests: one word per column. operation = load writes the four elements
//   into column "column" of the stored left matrix and yields no result.
//   operation = multiply takes column j of the right matrix and yields
//   column j of left * right on results, with saturated set if any row
//   clipped to the signed DATA_WIDTH range.
// Throughput: unless stalled, one word per cycle, loads and multiplies
//   mixed; a multiply right after a load already sees the new column.
// Pipeline: a multiply passes partial products, full products, sum and
//   the output register on its way to results. Four row lanes
//   each carry eight half-width multipliers, so the full rate holds.
// Stall: while results.ready is low the output register holds; pipeline
//   bubbles close up and requests.ready drops only once all three stages
//   and the output register hold multiply words.
// Reset: the stored left matrix is cleared to zero and the pipeline empties;
//   a multiply before any load returns zeros.
module matrix4_column_multiply #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    m4cm_in_if.sink    requests,
    m4cm_out_if.source results
);
    import m4cm_pkg::*;

    localparam int CELLS = NUM_ROWS * NUM_ROWS;

    logic [DATA_WIDTH-1:0]        left_reg [CELLS];
    logic signed [DATA_WIDTH-1:0] right_col [NUM_ROWS];
    logic signed [DATA_WIDTH-1:0] lane_left [NUM_ROWS][NUM_ROWS];
    logic signed [DATA_WIDTH-1:0] lane_value [NUM_ROWS];
    logic [NUM_ROWS-1:0]          lane_clip;

    logic             v1_reg, v2_reg, v3_reg;
    logic             v1_next;
    logic [COL_W-1:0] col1_reg, col2_reg, col3_reg;
    logic             out_free;
    logic             accept;
    m4cm_adv_t        adv;

    always_comb
    begin
        adv.s3         = !v3_reg || out_free;
        adv.s2         = !v2_reg || adv.s3;
        adv.s1         = !v1_reg || adv.s2;
        requests.ready = adv.s1;
        accept         = requests.valid && adv.s1;
        v1_next        = accept && (requests.operation == OP_MULTIPLY);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int e = 0; e < CELLS; e++)
            begin
                left_reg[e] <= '0;
            end
        end
        else
        begin
            if (adv.s1)
            begin
                v1_reg <= v1_next;
            end
            if (adv.s2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv.s3)
            begin
                v3_reg <= v2_reg;
            end
            if (accept && (requests.operation == OP_LOAD))
            begin
                for (int r = 0; r < NUM_ROWS; r++)
                begin
                    left_reg[{requests.column, ROW_W'(r)}] <= right_col[r];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            col1_reg <= requests.column;
        end
        if (adv.s2)
        begin
            col2_reg <= col1_reg;
        end
        if (adv.s3)
        begin
            col3_reg <= col2_reg;
        end
    end

    always_comb
    begin
        right_col[0] = requests.elem_row0;
        right_col[1] = requests.elem_row1;
        right_col[2] = requests.elem_row2;
        right_col[3] = requests.elem_row3;
        // lane i sees row i of the left matrix
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            for (int k = 0; k < NUM_ROWS; k++)
            begin
                lane_left[i][k] = left_reg[k * NUM_ROWS + i];
            end
        end
    end

    for (genvar i = 0; i < NUM_ROWS; i++)
    begin : g_lane
        m4cm_lane #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lane (
            .clk       (clk),
            .adv       (adv),
            .left_row  (lane_left[i]),
            .right_col (right_col),
            .value     (lane_value[i]),
            .clipped   (lane_clip[i])
        );
    end

    m4cm_merge #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (v3_reg),
        .in_column  (col3_reg),
        .lane_value (lane_value),
        .lane_clip  (lane_clip),
        .out_free   (out_free),
        .results    (results)
    );

endmodule

`default_nettype wire
